### design/gpio_port_register_block_top_defines.svh
// Assertion macros for the GPIO port register block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GPIO_PORT_REGISTER_BLOCK_TOP_DEFINES_SVH
`define GPIO_PORT_REGISTER_BLOCK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GPR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/gpr_pkg.sv
// Shared types, register codes and field-mask functions of the GPIO port block.
// No dependencies; used by the top level.
`default_nettype none

package gpr_pkg;

	localparam int unsigned PIN_COUNT = 16;
	localparam logic [15:0] PIN_MASK = 16'((32'd1 << PIN_COUNT) - 32'd1);
	localparam logic [31:0] KEY_BIT = 32'h0001_0000;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [3:0] {
		REG_MODE     = 4'd0,
		REG_TYPE     = 4'd1,
		REG_SPEED    = 4'd2,
		REG_PULL     = 4'd3,
		REG_INPUT    = 4'd4,
		REG_OUTPUT   = 4'd5,
		REG_SETRESET = 4'd6,
		REG_LOCK     = 4'd7,
		REG_ALTLOW   = 4'd8,
		REG_ALTHIGH  = 4'd9
	} reg_idx_t;

	typedef enum logic [1:0] {
		LOCK_IDLE = 2'd0,
		LOCK_KEY1 = 2'd1,
		LOCK_KEY0 = 2'd2
	} lock_stage_t;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  reg_index;
		logic [31:0] write_data;
		logic [15:0] pin_levels;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [15:0] output_levels;
		logic        lock_active;
		logic        write_ignored;
	} rsp_t;

	typedef struct packed {
		logic [31:0] value;
		logic        refused;
	} guard_t;

	// Two bits per pin for all sixteen pins.
	function automatic logic [31:0] spread2(input logic [15:0] pins);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			if (pins[i]) begin
				m[2*i +: 2] = 2'b11;
			end
		end
		return m;
	endfunction

	// Four bits per pin for a group of eight pins.
	function automatic logic [31:0] spread4(input logic [7:0] pins);
		logic [31:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (pins[i]) begin
				m[4*i +: 4] = 4'hF;
			end
		end
		return m;
	endfunction

	// Writes data except locked bits; flags a write that would change a locked bit.
	function automatic guard_t guarded(input logic [31:0] old, input logic [31:0] data,
			input logic [31:0] impl, input logic [31:0] locked);
		logic [31:0] old_i;
		logic [31:0] lk;
		guard_t g;
		old_i = old & impl;
		lk = locked & impl;
		g.value = (old_i & lk) | (data & impl & ~lk);
		g.refused = |((old_i ^ data) & lk);
		return g;
	endfunction

	localparam logic [31:0] IMPL2   = spread2(PIN_MASK);
	localparam logic [31:0] IMPL1   = {16'h0000, PIN_MASK};
	localparam logic [31:0] IMPL_AL = spread4(PIN_MASK[7:0]);
	localparam logic [31:0] IMPL_AH = spread4(PIN_MASK[15:8]);

endpackage

`default_nettype wire

### design/gpr_req_if.sv
// Request channel of the GPIO port block: one register access per item.
// No dependencies.
`default_nettype none

interface gpr_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [3:0]  reg_index;
	logic [31:0] write_data;
	logic [15:0] pin_levels;

	modport source (output valid, cmd, reg_index, write_data, pin_levels, input ready);
	modport sink (input valid, cmd, reg_index, write_data, pin_levels, output ready);
endinterface

`default_nettype wire

### design/gpr_rsp_if.sv
// Response channel of the GPIO port block: one result item per access.
// No dependencies.
`default_nettype none

interface gpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic [15:0] output_levels;
	logic        lock_active;
	logic        write_ignored;

	modport source (output valid, read_data, output_levels, lock_active, write_ignored,
		input ready);
	modport sink (input valid, read_data, output_levels, lock_active, write_ignored,
		output ready);
endinterface

`default_nettype wire

### design/gpio_port_register_block_top.sv
// Top level of the GPIO port register block: ten word registers and lock logic.
// Depends on gpr_pkg, gpr_req_if, gpr_rsp_if and the assertion macro header.
//
//   channel | direction | carries
//   req     | in        | cmd, reg_index, write_data, pin_levels
//   rsp     | out       | read_data, output_levels, lock_active, write_ignored
//
// One item is accepted per cycle unless a stalled result keeps the input register full;
// each access passes through the input register, which registers it, then the
// register update, which also loads the result register that offers its result.
// Reset clears the valid flags, every configuration register, the output latch and the lock state.
// A stalled result holds the pipeline; the input register still fills behind it.
`default_nettype none
`include "gpio_port_register_block_top_defines.svh"

module gpio_port_register_block_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gpr_req_if.sink    req,
	gpr_rsp_if.source  rsp
);

	gpr_pkg::req_t req_s1;
	logic          req_valid_s1;
	gpr_pkg::rsp_t rsp_s2;
	logic          rsp_valid_s2;
	logic          advance;

	logic [31:0] mode_q, speed_q, pull_q, alt_low_q, alt_high_q;
	logic [15:0] drive_q, out_latch_q, lock_mask_q;
	logic        lock_key_q;
	gpr_pkg::lock_stage_t lock_stage_q;

	logic [31:0] mode_d, speed_d, pull_d, alt_low_d, alt_high_d;
	logic [15:0] drive_d, out_latch_d, lock_mask_d;
	logic        lock_key_d;
	gpr_pkg::lock_stage_t lock_stage_d;
	gpr_pkg::rsp_t rsp_d;

	logic [15:0] frozen;
	logic [31:0] data;
	logic        key;
	logic [15:0] lmask;
	logic        same;
	gpr_pkg::guard_t g_mode, g_drive, g_speed, g_pull, g_al, g_ah;

	assign advance = req_valid_s1 && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				req_valid_s1 <= req.valid;
			end
			if (advance) begin
				rsp_valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= '{cmd: req.cmd, reg_index: req.reg_index,
				write_data: req.write_data, pin_levels: req.pin_levels};
		end
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			drive_q      <= '0;
			speed_q      <= '0;
			pull_q       <= '0;
			out_latch_q  <= '0;
			alt_low_q    <= '0;
			alt_high_q   <= '0;
			lock_mask_q  <= '0;
			lock_key_q   <= 1'b0;
			lock_stage_q <= gpr_pkg::LOCK_IDLE;
		end else if (advance) begin
			mode_q       <= mode_d;
			drive_q      <= drive_d;
			speed_q      <= speed_d;
			pull_q       <= pull_d;
			out_latch_q  <= out_latch_d;
			alt_low_q    <= alt_low_d;
			alt_high_q   <= alt_high_d;
			lock_mask_q  <= lock_mask_d;
			lock_key_q   <= lock_key_d;
			lock_stage_q <= lock_stage_d;
		end
	end

	assign frozen = lock_key_q ? (lock_mask_q & gpr_pkg::PIN_MASK) : 16'h0000;
	assign data   = req_s1.write_data;
	assign key    = |(data & gpr_pkg::KEY_BIT);
	assign lmask  = data[15:0] & gpr_pkg::PIN_MASK;
	assign same   = (lmask == lock_mask_q);

	assign g_mode  = gpr_pkg::guarded(mode_q, data, gpr_pkg::IMPL2, gpr_pkg::spread2(frozen));
	assign g_drive = gpr_pkg::guarded({16'h0000, drive_q}, data, gpr_pkg::IMPL1,
		{16'h0000, frozen});
	assign g_speed = gpr_pkg::guarded(speed_q, data, gpr_pkg::IMPL2, gpr_pkg::spread2(frozen));
	assign g_pull  = gpr_pkg::guarded(pull_q, data, gpr_pkg::IMPL2, gpr_pkg::spread2(frozen));
	assign g_al    = gpr_pkg::guarded(alt_low_q, data, gpr_pkg::IMPL_AL,
		gpr_pkg::spread4(frozen[7:0]));
	assign g_ah    = gpr_pkg::guarded(alt_high_q, data, gpr_pkg::IMPL_AH,
		gpr_pkg::spread4(frozen[15:8]));

	always_comb begin
		mode_d       = mode_q;
		drive_d      = drive_q;
		speed_d      = speed_q;
		pull_d       = pull_q;
		out_latch_d  = out_latch_q;
		alt_low_d    = alt_low_q;
		alt_high_d   = alt_high_q;
		lock_mask_d  = lock_mask_q;
		lock_key_d   = lock_key_q;
		lock_stage_d = lock_stage_q;
		rsp_d.read_data     = '0;
		rsp_d.write_ignored = 1'b0;

		if (req_s1.cmd == gpr_pkg::CMD_READ) begin
			case (gpr_pkg::reg_idx_t'(req_s1.reg_index))
				gpr_pkg::REG_MODE:    rsp_d.read_data = mode_q;
				gpr_pkg::REG_TYPE:    rsp_d.read_data = {16'h0000, drive_q};
				gpr_pkg::REG_SPEED:   rsp_d.read_data = speed_q;
				gpr_pkg::REG_PULL:    rsp_d.read_data = pull_q;
				gpr_pkg::REG_INPUT: begin
					rsp_d.read_data = {16'h0000, req_s1.pin_levels & gpr_pkg::PIN_MASK};
				end
				gpr_pkg::REG_OUTPUT:  rsp_d.read_data = {16'h0000, out_latch_q};
				gpr_pkg::REG_LOCK:    rsp_d.read_data = {15'h0000, lock_key_q, lock_mask_q};
				gpr_pkg::REG_ALTLOW:  rsp_d.read_data = alt_low_q;
				gpr_pkg::REG_ALTHIGH: rsp_d.read_data = alt_high_q;
				default:              rsp_d.read_data = '0;
			endcase
		end else begin
			case (gpr_pkg::reg_idx_t'(req_s1.reg_index))
				gpr_pkg::REG_MODE: begin
					mode_d = g_mode.value;
					rsp_d.write_ignored = g_mode.refused;
				end
				gpr_pkg::REG_TYPE: begin
					drive_d = g_drive.value[15:0];
					rsp_d.write_ignored = g_drive.refused;
				end
				gpr_pkg::REG_SPEED: begin
					speed_d = g_speed.value;
					rsp_d.write_ignored = g_speed.refused;
				end
				gpr_pkg::REG_PULL: begin
					pull_d = g_pull.value;
					rsp_d.write_ignored = g_pull.refused;
				end
				gpr_pkg::REG_OUTPUT: begin
					out_latch_d = data[15:0] & gpr_pkg::PIN_MASK;
				end
				gpr_pkg::REG_SETRESET: begin
					out_latch_d = ((out_latch_q & ~data[31:16]) | data[15:0]) & gpr_pkg::PIN_MASK;
				end
				gpr_pkg::REG_LOCK: begin
					if (lock_key_q) begin
						rsp_d.write_ignored = 1'b1;
					end else begin
						if (lock_stage_q == gpr_pkg::LOCK_KEY1 && !key && same) begin
							lock_stage_d = gpr_pkg::LOCK_KEY0;
						end else if (lock_stage_q == gpr_pkg::LOCK_KEY0 && key && same) begin
							lock_stage_d = gpr_pkg::LOCK_IDLE;
							lock_key_d = 1'b1;
						end else begin
							lock_stage_d = key ? gpr_pkg::LOCK_KEY1 : gpr_pkg::LOCK_IDLE;
						end
						lock_mask_d = lmask;
					end
				end
				gpr_pkg::REG_ALTLOW: begin
					alt_low_d = g_al.value;
					rsp_d.write_ignored = g_al.refused;
				end
				gpr_pkg::REG_ALTHIGH: begin
					alt_high_d = g_ah.value;
					rsp_d.write_ignored = g_ah.refused;
				end
				default: rsp_d.write_ignored = 1'b1;
			endcase
		end

		rsp_d.output_levels = out_latch_d;
		rsp_d.lock_active   = lock_key_d;
	end

	assign rsp.valid         = rsp_valid_s2;
	assign rsp.read_data     = rsp_s2.read_data;
	assign rsp.output_levels = rsp_s2.output_levels;
	assign rsp.lock_active   = rsp_s2.lock_active;
	assign rsp.write_ignored = rsp_s2.write_ignored;

	`GPR_ASSERT_NXT(a_lock_sticky, lock_key_q, lock_key_q, "Lock cleared without reset.")
	`GPR_ASSERT_IMP(a_locked_idle, lock_key_q, lock_stage_q == gpr_pkg::LOCK_IDLE,
		"Lock sequence active after lock completed.")
	`GPR_ASSERT_NXT(a_read_keeps_latch, advance && req_s1.cmd == gpr_pkg::CMD_READ,
		$stable(out_latch_q), "A read changed the output latch.")
	`GPR_ASSERT_NXT(a_read_not_flagged, advance && req_s1.cmd == gpr_pkg::CMD_READ,
		!rsp_s2.write_ignored, "A read was flagged as an ignored write.")
	`GPR_ASSERT_IMP(a_rsp_tracks_latch, rsp_valid_s2, rsp_s2.output_levels == out_latch_q,
		"Pending result disagrees with the output latch.")

endmodule

`default_nettype wire
